[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL. Both expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen on a rising edge outside reset.
`define ASSERT_NEVER(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[rtl/gb_pkg.sv]
package gb_pkg;

    localparam int KERNEL_SIZE    = 5;
    localparam int NUM_CLASSES    = 6;
    localparam int OUT_FIFO_DEPTH = 8;
    localparam int FIFO_AW        = $clog2(OUT_FIFO_DEPTH);
    localparam int FIFO_LW        = $clog2(OUT_FIFO_DEPTH + 1);

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_W_CENTER     = 3'd0;
    localparam logic [2:0] REG_W_NEAR_EDGE  = 3'd1;
    localparam logic [2:0] REG_W_NEAR_DIAG  = 3'd2;
    localparam logic [2:0] REG_W_FAR_EDGE   = 3'd3;
    localparam logic [2:0] REG_W_FAR_KNIGHT = 3'd4;
    localparam logic [2:0] REG_W_FAR_CORNER = 3'd5;
    localparam logic [2:0] REG_WIDTH        = 3'd6;
    localparam logic [2:0] REG_HEIGHT       = 3'd7;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pix_t;

    typedef pix_t [KERNEL_SIZE-1:0] col_t;
    typedef logic [2:0] tap_idx_t;
    typedef tap_idx_t [KERNEL_SIZE-1:0] idx5_t;
    typedef logic [NUM_CLASSES-1:0][15:0] weights_t;
    typedef logic [FIFO_LW-1:0] level_t;

    typedef struct packed {
        logic has_out;
        logic eol;
        logic eof;
    } ctrl_t;

    typedef struct packed {
        logic       eof;
        logic       eol;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } res_t;

endpackage

[rtl/gb_line_buf.sv]
module gb_line_buf
    import gb_pkg::*;
#(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
)
(
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  pix_t          wr_pix,
    input  idx5_t         vidx,
    output col_t          col
);

    pix_t rd_reg [KERNEL_SIZE-1];
    pix_t lines [KERNEL_SIZE];

    // Each line store shifts its column down by one row when a pixel is written.
    for (genvar i = 0; i < KERNEL_SIZE - 1; i++) begin : g_line
        pix_t mem [DEPTH];
        pix_t wdata;

        if (i == 0) begin : g_first
            assign wdata = wr_pix;
        end
        else begin : g_rest
            assign wdata = rd_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            if (wr_en)
            begin
                mem[wr_addr] <= wdata;
            end
            if (rd_en)
            begin
                rd_reg[i] <= mem[rd_addr];
            end
        end
    end

    always_comb
    begin
        lines[0] = wr_pix;
        for (int j = 1; j < KERNEL_SIZE; j++)
        begin
            lines[j] = rd_reg[j-1];
        end
    end

    // Row replication at the top and bottom edges picks an older or newer line.
    always_comb
    begin
        for (int dy = 0; dy < KERNEL_SIZE; dy++)
        begin
            col[dy] = lines[0];
            for (int j = 1; j < KERNEL_SIZE; j++)
            begin
                if (vidx[dy] == 3'(j))
                begin
                    col[dy] = lines[j];
                end
            end
        end
    end

endmodule

[rtl/gb_kernel.sv]
`include "assert_macros.svh"

module gb_kernel
    import gb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  col_t       col,
    input  idx5_t      hidx,
    input  ctrl_t      ctrl,
    input  weights_t   weight,
    output logic       res_valid,
    output res_t       res,
    output logic [1:0] busy
);

    col_t  hist_reg [KERNEL_SIZE];

    logic  b_valid_reg;
    idx5_t b_hidx_reg;
    ctrl_t b_ctrl_reg;

    logic  c_valid_reg;
    ctrl_t c_ctrl_reg;
    logic [2:0][NUM_CLASSES-1:0][10:0] c_sum_reg;

    logic  d_valid_reg;
    ctrl_t d_ctrl_reg;
    logic [2:0][NUM_CLASSES-1:0][26:0] d_prod_reg;

    col_t  win [KERNEL_SIZE];
    logic [2:0][NUM_CLASSES-1:0][10:0] csum;
    logic [2:0][29:0] total;
    logic [2:0][13:0] scaled;
    logic [2:0][7:0]  sat;

    function automatic int tap_class(input int dy, input int dx);
        int a;
        int b;
        int t;
        int cls;
        begin
            a = (dy > 2) ? dy - 2 : 2 - dy;
            b = (dx > 2) ? dx - 2 : 2 - dx;
            if (a < b)
            begin
                t = a;
                a = b;
                b = t;
            end
            if (a == 0)
                cls = 0;
            else if (a == 1)
                cls = (b == 0) ? 1 : 2;
            else if (b == 0)
                cls = 3;
            else if (b == 1)
                cls = 4;
            else
                cls = 5;
            return cls;
        end
    endfunction

    // Column history: entry 0 is the newest vertical column.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            hist_reg[0] <= col;
            for (int j = 1; j < KERNEL_SIZE; j++)
            begin
                hist_reg[j] <= hist_reg[j-1];
            end
            b_hidx_reg <= hidx;
            b_ctrl_reg <= ctrl;
        end
        c_ctrl_reg <= b_ctrl_reg;
        c_sum_reg  <= csum;
        d_ctrl_reg <= c_ctrl_reg;
        for (int ch = 0; ch < 3; ch++)
        begin
            for (int k = 0; k < NUM_CLASSES; k++)
            begin
                d_prod_reg[ch][k] <= 27'(c_sum_reg[ch][k]) * 27'(weight[k]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= push && ctrl.has_out;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    // Column replication at the left and right edges picks a repeated column.
    always_comb
    begin
        for (int dx = 0; dx < KERNEL_SIZE; dx++)
        begin
            win[dx] = hist_reg[0];
            for (int j = 1; j < KERNEL_SIZE; j++)
            begin
                if (b_hidx_reg[dx] == 3'(j))
                begin
                    win[dx] = hist_reg[j];
                end
            end
        end
    end

    // Taps that share a weight are added before the multiply.
    always_comb
    begin
        csum = '0;
        for (int dy = 0; dy < KERNEL_SIZE; dy++)
        begin
            for (int dx = 0; dx < KERNEL_SIZE; dx++)
            begin
                csum[0][tap_class(dy, dx)] += 11'(win[dx][dy].blue);
                csum[1][tap_class(dy, dx)] += 11'(win[dx][dy].green);
                csum[2][tap_class(dy, dx)] += 11'(win[dx][dy].red);
            end
        end
    end

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            total[ch] = '0;
            for (int k = 0; k < NUM_CLASSES; k++)
            begin
                total[ch] += 30'(d_prod_reg[ch][k]);
            end
            scaled[ch] = total[ch][29:16];
            sat[ch]    = (scaled[ch] > 14'd255) ? 8'd255 : scaled[ch][7:0];
        end
    end

    assign res_valid = d_valid_reg;
    assign res.blue  = sat[0];
    assign res.green = sat[1];
    assign res.red   = sat[2];
    assign res.eol   = d_ctrl_reg.eol;
    assign res.eof   = d_ctrl_reg.eof;
    assign busy      = 2'(b_valid_reg) + 2'(c_valid_reg) + 2'(d_valid_reg);

    `ASSERT_CLK(kern_pipe_flow, b_valid_reg |=> c_valid_reg, "kernel stage lost a transaction")

endmodule

[rtl/gb_out_fifo.sv]
`include "assert_macros.svh"

module gb_out_fifo
    import gb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr_en,
    input  res_t   wr_data,
    output logic   rd_valid,
    input  logic   rd_stall,
    output res_t   rd_data,
    output level_t level
);

    res_t               buf_reg [OUT_FIFO_DEPTH];
    logic [FIFO_AW-1:0] head_reg;
    logic [FIFO_AW-1:0] tail_reg;
    level_t             count_reg;
    logic               rd;

    assign rd_valid = (count_reg != '0);
    assign rd       = rd_valid && !rd_stall;
    assign rd_data  = buf_reg[head_reg];
    assign level    = count_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            buf_reg[tail_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                tail_reg <= tail_reg + 1'b1;
            end
            if (rd)
            begin
                head_reg <= head_reg + 1'b1;
            end
            count_reg <= count_reg + level_t'(wr_en) - level_t'(rd);
        end
    end

    `ASSERT_NEVER(fifo_overflow, wr_en && !rd && (count_reg == FIFO_LW'(OUT_FIFO_DEPTH)), "result queue overflow")

endmodule

[rtl/gaussian_blur_5x5_rgb.sv]
// Streaming 5x5 Gaussian blur of 24-bit RGB pixels in raster order.
// Input channel: in_valid/in_stall with kind, in_blue, in_green, in_red. A frame
// is image_width*image_height pixels (kind 0) followed by 2*width+2 drain
// transactions that flush the tail; a drain transaction inside the frame is dropped.
// Output channel: out_valid/out_stall with the blurred pixel and end_of_row and
// end_of_frame flags. Output pixel p belongs to input transaction p+2*width+2
// and reaches the output through the input register, kernel stages b, c and d and the result queue.
// Throughput is one transaction per clock while in_stall is low; each line store
// is written once and read once per pixel, and the kernel math is a fixed pipeline.
// A stalled receiver fills an 8-deep result queue; in_stall rises only when
// the queue plus the results in flight would reach its depth.
// Configuration goes through the APB port at byte address 4*index. Write it only
// while the block is idle; writing the width or height restarts the frame.
// Reset loads the default kernel and 640x480 and restarts the frame. The line
// stores are not cleared: each frame writes every row before it is read.
`include "assert_macros.svh"

module gaussian_blur_5x5_rgb
    import gb_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [7:0]  in_blue,
    input  logic [7:0]  in_green,
    input  logic [7:0]  in_red,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_blue,
    output logic [7:0]  out_green,
    output logic [7:0]  out_red,
    output logic        end_of_row,
    output logic        end_of_frame
);

    localparam int CW = $clog2(MAX_WIDTH);

    weights_t       wt_reg;
    logic [11:0]    width_reg;
    logic [11:0]    height_reg;
    logic [CW-1:0]  col_reg;
    logic [12:0]    row_reg;
    logic [CW-1:0]  col_next;
    logic [12:0]    row_next;

    logic           a_valid_reg;
    pix_t           a_pix_reg;
    logic [CW-1:0]  a_col_reg;
    idx5_t          a_vidx_reg;
    idx5_t          a_hidx_reg;
    ctrl_t          a_ctrl_reg;

    logic           cfg_wr;
    logic [2:0]     cfg_idx;
    logic [13:0]    w_ext;
    logic [13:0]    w_sel;
    logic [CW:0]    w_eff;
    logic [CW:0]    wm1;
    logic [11:0]    h_eff;
    logic [12:0]    h13;
    logic [12:0]    rh1;
    logic           accept;
    logic           ignore;
    logic           go;
    logic           has_out;
    logic           eof_now;
    logic [CW:0]    ocol_w;
    logic [CW-1:0]  ocol;
    logic           ocol_last;
    logic           ocol_prev;
    idx5_t          hidx_now;
    idx5_t          vidx_now;
    ctrl_t          ctrl_now;
    pix_t           pix_now;
    col_t           vcol;
    logic           res_valid;
    res_t           res;
    res_t           out_res;
    logic [1:0]     kbusy;
    level_t         fifo_level;
    logic [FIFO_LW:0] need;

    // Configuration port.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    always_comb
    begin
        case (cfg_idx)
            REG_W_CENTER:     prdata = {16'b0, wt_reg[0]};
            REG_W_NEAR_EDGE:  prdata = {16'b0, wt_reg[1]};
            REG_W_NEAR_DIAG:  prdata = {16'b0, wt_reg[2]};
            REG_W_FAR_EDGE:   prdata = {16'b0, wt_reg[3]};
            REG_W_FAR_KNIGHT: prdata = {16'b0, wt_reg[4]};
            REG_W_FAR_CORNER: prdata = {16'b0, wt_reg[5]};
            REG_WIDTH:        prdata = {20'b0, width_reg};
            REG_HEIGHT:       prdata = {20'b0, height_reg};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wt_reg[0]  <= 16'd6521;
            wt_reg[1]  <= 16'd5755;
            wt_reg[2]  <= 16'd5079;
            wt_reg[3]  <= 16'd3957;
            wt_reg[4]  <= 16'd3492;
            wt_reg[5]  <= 16'd2401;
            width_reg  <= 12'd640;
            height_reg <= 12'd480;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_W_CENTER:     wt_reg[0]  <= pwdata[15:0];
                REG_W_NEAR_EDGE:  wt_reg[1]  <= pwdata[15:0];
                REG_W_NEAR_DIAG:  wt_reg[2]  <= pwdata[15:0];
                REG_W_FAR_EDGE:   wt_reg[3]  <= pwdata[15:0];
                REG_W_FAR_KNIGHT: wt_reg[4]  <= pwdata[15:0];
                REG_W_FAR_CORNER: wt_reg[5]  <= pwdata[15:0];
                REG_WIDTH:        width_reg  <= pwdata[11:0];
                REG_HEIGHT:       height_reg <= pwdata[11:0];
                default:          ;
            endcase
        end
    end

    // Effective frame size.
    always_comb
    begin
        w_ext = {2'b0, width_reg};
        w_sel = w_ext;
        if (w_ext < 14'd3)
            w_sel = 14'd3;
        else if (w_ext > 14'(MAX_WIDTH))
            w_sel = 14'(MAX_WIDTH);
        w_eff = w_sel[CW:0];
        wm1   = w_eff - 1'b1;
        h_eff = (height_reg < 12'd3) ? 12'd3 : height_reg;
        h13   = {1'b0, h_eff};
        rh1   = row_reg - h13 + 13'd1;
    end

    // Position decode for the transaction at the input.
    assign accept  = in_valid && !in_stall;
    assign ignore  = kind && (row_reg < h13);
    assign go      = accept && !ignore;
    assign has_out = (row_reg > 13'd2) || ((row_reg == 13'd2) && (col_reg >= CW'(2)));
    assign eof_now = has_out && (col_reg == CW'(1)) && (row_reg == h13 + 13'd2);

    // The centre column trails the input by two, wrapping into the previous row.
    always_comb
    begin
        if (col_reg >= CW'(2))
            ocol_w = {1'b0, col_reg} - (CW+1)'(2);
        else
            ocol_w = {1'b0, col_reg} + w_eff - (CW+1)'(2);
        ocol      = ocol_w[CW-1:0];
        ocol_last = ({1'b0, ocol} == wm1);
        ocol_prev = ({1'b0, ocol} == wm1 - 1'b1);

        hidx_now[0] = (ocol == '0) ? 3'd2 : ((ocol == CW'(1)) ? 3'd3 : 3'd4);
        hidx_now[1] = (ocol == '0) ? 3'd2 : 3'd3;
        hidx_now[2] = 3'd2;
        hidx_now[3] = ocol_last ? 3'd2 : 3'd1;
        hidx_now[4] = ocol_last ? 3'd2 : (ocol_prev ? 3'd1 : 3'd0);

        vidx_now[0] = (row_reg < 13'd4) ? row_reg[2:0] : 3'd4;
        vidx_now[1] = (row_reg < 13'd3) ? row_reg[2:0] : 3'd3;
        vidx_now[2] = (row_reg < 13'd2) ? row_reg[2:0] :
                      ((row_reg > h13 + 13'd1) ? rh1[2:0] : 3'd2);
        vidx_now[3] = (row_reg < 13'd1) ? 3'd0 :
                      ((row_reg > h13) ? rh1[2:0] : 3'd1);
        vidx_now[4] = (row_reg >= h13) ? rh1[2:0] : 3'd0;

        ctrl_now.has_out = has_out;
        ctrl_now.eol     = (col_reg == CW'(1));
        ctrl_now.eof     = eof_now;

        pix_now.blue  = in_blue;
        pix_now.green = in_green;
        pix_now.red   = in_red;
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_wr && ((cfg_idx == REG_WIDTH) || (cfg_idx == REG_HEIGHT)))
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (go)
        begin
            if (eof_now)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if ({1'b0, col_reg} == wm1)
            begin
                col_next = '0;
                row_next = row_reg + 13'd1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            a_valid_reg <= go;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            a_pix_reg  <= pix_now;
            a_col_reg  <= col_reg;
            a_vidx_reg <= vidx_now;
            a_hidx_reg <= hidx_now;
            a_ctrl_reg <= ctrl_now;
        end
    end

    gb_line_buf #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_buf (
        .clk     (clk),
        .rd_en   (go),
        .rd_addr (col_reg),
        .wr_en   (a_valid_reg),
        .wr_addr (a_col_reg),
        .wr_pix  (a_pix_reg),
        .vidx    (a_vidx_reg),
        .col     (vcol)
    );

    gb_kernel u_kernel (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (a_valid_reg),
        .col       (vcol),
        .hidx      (a_hidx_reg),
        .ctrl      (a_ctrl_reg),
        .weight    (wt_reg),
        .res_valid (res_valid),
        .res       (res),
        .busy      (kbusy)
    );

    gb_out_fifo u_out_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (res_valid),
        .wr_data  (res),
        .rd_valid (out_valid),
        .rd_stall (out_stall),
        .rd_data  (out_res),
        .level    (fifo_level)
    );

    // Results already in flight reserve their queue slots before a new transaction enters.
    assign need = {1'b0, fifo_level}
                + (FIFO_LW+1)'(a_valid_reg && a_ctrl_reg.has_out)
                + (FIFO_LW+1)'(kbusy);
    assign in_stall = (need >= (FIFO_LW+1)'(OUT_FIFO_DEPTH));

    assign out_blue     = out_res.blue;
    assign out_green    = out_res.green;
    assign out_red      = out_res.red;
    assign end_of_row   = out_res.eol;
    assign end_of_frame = out_res.eof;

    `ASSERT_CLK(top_eof_has_eol, out_valid && end_of_frame |-> end_of_row, "frame end without row end")
    `ASSERT_CLK(top_eof_restart, go && eof_now |=> (col_reg == '0) && (row_reg == '0), "counters did not restart after frame end")

endmodule
